FILE: src/lci_pkg.sv
// Shared types and constants for the LED chaser intensity block.
// Holds the fixed head table and the field widths; no dependencies.
`default_nettype none

package lci_pkg;

    localparam int FRAME_W     = 24;
    localparam int LED_W       = 10;
    localparam int COUNT_W     = 11;
    localparam int GRAD_W      = 6;
    localparam int START_W     = 9;
    localparam int TABLE_HEADS = 14;
    localparam int FAST_HEADS  = 2;
    localparam int NEAR_SPAN   = 19;
    localparam int RESET_COUNT = 420;

    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [LED_W-1:0]   led_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [GRAD_W-1:0]  grad_t;

    localparam grad_t FAST_PEAK = 6'd38;
    localparam grad_t SLOW_PEAK = 6'd19;

    localparam logic [START_W-1:0] HEAD_START [TABLE_HEADS] = '{
        9'd19, 9'd246, 9'd0, 9'd38, 9'd76, 9'd114, 9'd152,
        9'd190, 9'd227, 9'd265, 9'd303, 9'd341, 9'd379, 9'd417
    };

endpackage

`default_nettype wire

FILE: src/lci_mod_cell.sv
// One cell of the remainder chain: takes one dividend bit per lane and
// reduces each lane's running remainder modulo the ring count. Uses lci_pkg.
`default_nettype none

module lci_mod_cell #(
    parameter int LANES = 15,
    parameter int MW    = 11
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [MW-1:0]             m,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire lci_pkg::frame_t           in_frame,
    input  wire lci_pkg::led_t             in_led,
    input  wire logic [LANES-1:0][MW-1:0]  in_rem,
    input  wire logic [LANES-1:0]          in_bits,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output lci_pkg::frame_t                out_frame,
    output lci_pkg::led_t                  out_led,
    output logic [LANES-1:0][MW-1:0]       out_rem
);
    import lci_pkg::*;

    logic                     valid_reg;
    frame_t                   frame_reg;
    led_t                     led_reg;
    logic [LANES-1:0][MW-1:0] rem_reg;
    logic [LANES-1:0][MW-1:0] rem_next;
    logic [LANES-1:0][MW:0]   trial;
    logic                     advance;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            trial[l] = {in_rem[l], in_bits[l]};
            if (trial[l] >= {1'b0, m})
            begin
                rem_next[l] = MW'(trial[l] - {1'b0, m});
            end
            else
            begin
                rem_next[l] = trial[l][MW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            frame_reg <= in_frame;
            led_reg   <= in_led;
            rem_reg   <= rem_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_frame = frame_reg;
    assign out_led   = led_reg;
    assign out_rem   = rem_reg;

endmodule

`default_nettype wire

FILE: src/lci_mod_chain.sv
// Row of remainder cells, one per frame bit, that reduces the frame and each
// head start offset modulo the ring count. Uses lci_pkg and lci_mod_cell.
`default_nettype none

module lci_mod_chain #(
    parameter int LANES = 15,
    parameter int MW    = 11
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [MW-1:0]             m,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire lci_pkg::frame_t           in_frame,
    input  wire lci_pkg::led_t             in_led,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output lci_pkg::led_t                  out_led,
    output logic [LANES-1:0][MW-1:0]       out_rem
);
    import lci_pkg::*;

    logic                     vld_w  [FRAME_W+1];
    logic                     rdy_w  [FRAME_W+1];
    frame_t                   frame_w[FRAME_W];
    led_t                     led_w  [FRAME_W+1];
    logic [LANES-1:0][MW-1:0] rem_w  [FRAME_W+1];
    logic [LANES-1:0]         bits_w [FRAME_W];

    assign vld_w[0]   = in_valid;
    assign in_ready   = rdy_w[0];
    assign frame_w[0] = in_frame;
    assign led_w[0]   = in_led;
    assign rem_w[0]   = '0;

    assign out_valid       = vld_w[FRAME_W];
    assign rdy_w[FRAME_W]  = out_ready;
    assign out_led         = led_w[FRAME_W];
    assign out_rem         = rem_w[FRAME_W];

    for (genvar k = 0; k < FRAME_W; k++)
    begin : g_cell
        localparam int B = FRAME_W - 1 - k;

        assign bits_w[k][0] = frame_w[k][B];

        for (genvar j = 1; j < LANES; j++)
        begin : g_lane
            if (B < START_W)
            begin : g_bit
                assign bits_w[k][j] = HEAD_START[j-1][B];
            end
            else
            begin : g_zero
                assign bits_w[k][j] = 1'b0;
            end
        end

        if (k < FRAME_W - 1)
        begin : g_mid
            lci_mod_cell #(
                .LANES(LANES),
                .MW   (MW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .m        (m),
                .in_valid (vld_w[k]),
                .in_ready (rdy_w[k]),
                .in_frame (frame_w[k]),
                .in_led   (led_w[k]),
                .in_rem   (rem_w[k]),
                .in_bits  (bits_w[k]),
                .out_valid(vld_w[k+1]),
                .out_ready(rdy_w[k+1]),
                .out_frame(frame_w[k+1]),
                .out_led  (led_w[k+1]),
                .out_rem  (rem_w[k+1])
            );
        end
        else
        begin : g_last
            lci_mod_cell #(
                .LANES(LANES),
                .MW   (MW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .m        (m),
                .in_valid (vld_w[k]),
                .in_ready (rdy_w[k]),
                .in_frame (frame_w[k]),
                .in_led   (led_w[k]),
                .in_rem   (rem_w[k]),
                .in_bits  (bits_w[k]),
                .out_valid(vld_w[k+1]),
                .out_ready(rdy_w[k+1]),
                .out_frame(),
                .out_led  (led_w[k+1]),
                .out_rem  (rem_w[k+1])
            );
        end
    end

endmodule

`default_nettype wire

FILE: src/lci_nearest.sv
// Places the heads on the ring, measures the forward distance from the LED,
// picks the nearest head through a registered tree and maps it to a gradient.
// Uses lci_pkg.
`default_nettype none

module lci_nearest #(
    parameter int LANES = 15,
    parameter int MW    = 11
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [MW-1:0]             m,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [LANES-1:0][MW-1:0]  in_rem,
    input  wire lci_pkg::led_t             in_led,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output lci_pkg::grad_t                 out_grad
);
    import lci_pkg::*;

    localparam int NH = LANES - 1;
    localparam int IW = (NH > 1) ? $clog2(NH) : 1;
    localparam int LV = $clog2(NH);
    localparam int ST = 3 + LV + 1;
    localparam int XW = (MW > LED_W) ? MW : LED_W;

    logic vld_reg [ST];
    logic en      [ST+1];

    logic [NH-1:0][MW-1:0] pos0_reg;
    logic [NH-1:0][MW-1:0] pos0_next;
    logic [NH-1:0][MW:0]   sum0;
    logic [MW-1:0]         half0_reg;
    led_t                  led0_reg;

    logic [NH-1:0][MW-1:0] pos1_reg;
    logic [NH-1:0][MW-1:0] pos1_next;
    logic [NH-1:0][MW:0]   sum1;
    led_t                  led1_reg;

    logic [NH-1:0][MW-1:0] dist_reg;
    logic [NH-1:0][MW-1:0] dist_next;
    logic [NH-1:0][XW:0]   diff;
    logic                  hit_reg;
    logic                  hit_next;

    logic [NH-1:0][MW-1:0] src_d  [LV];
    logic [NH-1:0][IW-1:0] src_i  [LV];
    logic                  src_h  [LV];
    logic [NH-1:0][MW-1:0] nd     [LV];
    logic [NH-1:0][IW-1:0] ni     [LV];
    logic [NH-1:0][MW-1:0] td_reg [LV];
    logic [NH-1:0][IW-1:0] ti_reg [LV];
    logic                  th_reg [LV];

    logic [MW-1:0]         best_d;
    logic [IW-1:0]         best_i;
    grad_t                 grad_reg;
    grad_t                 grad_next;

    always_comb
    begin
        en[ST] = out_ready;
        for (int s = ST - 1; s >= 0; s--)
        begin
            en[s] = !vld_reg[s] || en[s+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[ST-1];
    assign out_grad  = grad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < ST; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < ST; s++)
            begin
                if (en[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // Head start offset plus phase, both already reduced.
    always_comb
    begin
        for (int j = 0; j < NH; j++)
        begin
            sum0[j] = {1'b0, in_rem[j+1]} + {1'b0, in_rem[0]};
            if (sum0[j] >= {1'b0, m})
            begin
                pos0_next[j] = MW'(sum0[j] - {1'b0, m});
            end
            else
            begin
                pos0_next[j] = sum0[j][MW-1:0];
            end
        end
    end

    // The fast heads move a further half phase.
    always_comb
    begin
        for (int j = 0; j < NH; j++)
        begin
            sum1[j] = {1'b0, pos0_reg[j]} + {1'b0, half0_reg};
            if (j >= FAST_HEADS)
            begin
                pos1_next[j] = pos0_reg[j];
            end
            else if (sum1[j] >= {1'b0, m})
            begin
                pos1_next[j] = MW'(sum1[j] - {1'b0, m});
            end
            else
            begin
                pos1_next[j] = sum1[j][MW-1:0];
            end
        end
    end

    always_comb
    begin
        hit_next = XW'(led1_reg) < XW'(m);
        for (int j = 0; j < NH; j++)
        begin
            diff[j] = {1'b0, XW'(pos1_reg[j])} - {1'b0, XW'(led1_reg)};
            if (diff[j][XW])
            begin
                dist_next[j] = MW'(diff[j] + {1'b0, XW'(m)});
            end
            else
            begin
                dist_next[j] = MW'(diff[j]);
            end
        end
    end

    // Each tree level halves the candidates; the left one keeps a tie.
    always_comb
    begin
        for (int l = 0; l < LV; l++)
        begin
            if (l == 0)
            begin
                src_d[l] = dist_reg;
                src_h[l] = hit_reg;
                for (int j = 0; j < NH; j++)
                begin
                    src_i[l][j] = IW'(j);
                end
            end
            else
            begin
                src_d[l] = td_reg[l-1];
                src_i[l] = ti_reg[l-1];
                src_h[l] = th_reg[l-1];
            end
        end
        for (int l = 0; l < LV; l++)
        begin
            for (int j = 0; j < NH; j++)
            begin
                nd[l][j] = '0;
                ni[l][j] = '0;
                if (2 * j + 1 < ((NH + (1 << l) - 1) >> l))
                begin
                    if (src_d[l][2*j] <= src_d[l][2*j+1])
                    begin
                        nd[l][j] = src_d[l][2*j];
                        ni[l][j] = src_i[l][2*j];
                    end
                    else
                    begin
                        nd[l][j] = src_d[l][2*j+1];
                        ni[l][j] = src_i[l][2*j+1];
                    end
                end
                else if (2 * j < ((NH + (1 << l) - 1) >> l))
                begin
                    nd[l][j] = src_d[l][2*j];
                    ni[l][j] = src_i[l][2*j];
                end
            end
        end
    end

    assign best_d = td_reg[LV-1][0];
    assign best_i = ti_reg[LV-1][0];

    always_comb
    begin
        grad_next = '0;
        if (th_reg[LV-1] && best_d < MW'(NEAR_SPAN))
        begin
            if (int'(best_i) < FAST_HEADS)
            begin
                grad_next = FAST_PEAK - GRAD_W'(best_d);
            end
            else
            begin
                grad_next = SLOW_PEAK - GRAD_W'(best_d);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
        begin
            pos0_reg  <= pos0_next;
            half0_reg <= in_rem[0] >> 1;
            led0_reg  <= in_led;
        end
        if (en[1] && vld_reg[0])
        begin
            pos1_reg <= pos1_next;
            led1_reg <= led0_reg;
        end
        if (en[2] && vld_reg[1])
        begin
            dist_reg <= dist_next;
            hit_reg  <= hit_next;
        end
        for (int l = 0; l < LV; l++)
        begin
            if (en[3+l] && vld_reg[2+l])
            begin
                td_reg[l] <= nd[l];
                ti_reg[l] <= ni[l];
                th_reg[l] <= src_h[l];
            end
        end
        if (en[ST-1] && vld_reg[ST-2])
        begin
            grad_reg <= grad_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/led_chaser_intensity.sv
// Top level of the LED chaser intensity block with its count register.
// Uses lci_pkg, lci_mod_chain and lci_nearest.
//
// The block takes one beat per cycle while the output side does not stall,
// and gives one gradient beat for each, in order. A beat passes through the
// row of remainder cells that reduces the frame one bit per cell, then head
// placement, distance, the nearest-head tree and the output register. Every
// stage stalls only when the stage after it is full, so bubbles close up
// under back-pressure.
`default_nettype none

module led_chaser_intensity #(
    parameter int HEAD_COUNT = 14,
    parameter int MAX_LEDS   = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wen,
    input  wire lci_pkg::count_t               cfg_wdata,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // frame_number [23:0], led_index [33:24], zero [39:34]
    input  wire logic [39:0]                   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // gradient_index [5:0], zero [7:6]
    output logic [7:0]                         m_axis_tdata
);
    import lci_pkg::*;

    localparam int NH    = (HEAD_COUNT < TABLE_HEADS) ? HEAD_COUNT : TABLE_HEADS;
    localparam int LANES = NH + 1;
    localparam int MW    = $clog2(MAX_LEDS + 1);

    logic [MW-1:0]            count_reg;
    logic [MW-1:0]            count_next;
    logic                     mid_valid;
    logic                     mid_ready;
    led_t                     mid_led;
    logic [LANES-1:0][MW-1:0] mid_rem;
    grad_t                    grad;

    // A count of zero acts as one, and a count past the largest ring is clamped.
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            count_next = MW'(1);
        end
        else if (int'(cfg_wdata) > MAX_LEDS)
        begin
            count_next = MW'(MAX_LEDS);
        end
        else
        begin
            count_next = MW'(cfg_wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= MW'(RESET_COUNT);
        end
        else if (cfg_wen)
        begin
            count_reg <= count_next;
        end
    end

    lci_mod_chain #(
        .LANES(LANES),
        .MW   (MW)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .m        (count_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_frame (s_axis_tdata[FRAME_W-1:0]),
        .in_led   (s_axis_tdata[FRAME_W+LED_W-1:FRAME_W]),
        .out_valid(mid_valid),
        .out_ready(mid_ready),
        .out_led  (mid_led),
        .out_rem  (mid_rem)
    );

    lci_nearest #(
        .LANES(LANES),
        .MW   (MW)
    ) u_nearest (
        .clk      (clk),
        .rst_n    (rst_n),
        .m        (count_reg),
        .in_valid (mid_valid),
        .in_ready (mid_ready),
        .in_rem   (mid_rem),
        .in_led   (mid_led),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_grad (grad)
    );

    assign m_axis_tdata = {2'b00, grad};

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && int'(count_reg) <= MAX_LEDS)
        else $error("ring count left its legal range");

    a_grad_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[5:0] <= FAST_PEAK)
        else $error("gradient beat above the peak value");

    a_free_path: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled although the output side can move");

endmodule

`default_nettype wire

FILE: dv/led_chaser_intensity_tb.sv
// Self-checking testbench for led_chaser_intensity: a directed table, then random beats
// under several ring counts. Each output beat is checked against its known table value
// or a local gradient predictor. Depends on lci_pkg and led_chaser_intensity RTL only.
`default_nettype none

module led_chaser_intensity_tb;

    import lci_pkg::*;

    localparam int HEAD_COUNT   = 14;
    localparam int MAX_LEDS     = 1024;
    localparam int PHASES       = 9;
    localparam int PHASE_BEATS  = 95;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 40;

    typedef struct packed {
        logic   set_count;
        count_t count;
        frame_t frame;
        led_t   led;
        logic   known;
        grad_t  value;
    } chase_row_t;

    localparam int ROWS = 21;

    chase_row_t directed_rows [ROWS] = '{
        '{1'b0, 11'd0,    24'd0,        10'd0,    1'b1, 6'd19},
        '{1'b0, 11'd0,    24'd0,        10'd19,   1'b1, 6'd38},
        '{1'b0, 11'd0,    24'd0,        10'd1,    1'b1, 6'd20},
        '{1'b0, 11'd0,    24'd0,        10'd419,  1'b1, 6'd18},
        '{1'b0, 11'd0,    24'd0,        10'd420,  1'b1, 6'd0},
        '{1'b0, 11'd0,    24'd0,        10'd1023, 1'b1, 6'd0},
        '{1'b0, 11'd0,    24'hFFFFFF,   10'd0,    1'b0, 6'd0},
        '{1'b0, 11'd0,    24'hFFFFFF,   10'd418,  1'b0, 6'd0},
        '{1'b1, 11'd1,    24'd0,        10'd0,    1'b1, 6'd38},
        '{1'b0, 11'd0,    24'hFFFFFF,   10'd0,    1'b1, 6'd38},
        '{1'b0, 11'd0,    24'd0,        10'd1,    1'b1, 6'd0},
        '{1'b1, 11'd0,    24'h123456,   10'd0,    1'b1, 6'd38},
        '{1'b0, 11'd0,    24'd0,        10'd1023, 1'b1, 6'd0},
        '{1'b1, 11'd2047, 24'd0,        10'd1023, 1'b1, 6'd18},
        '{1'b0, 11'd0,    24'hFFFFFF,   10'd1023, 1'b0, 6'd0},
        '{1'b0, 11'd0,    24'h000400,   10'd512,  1'b0, 6'd0},
        '{1'b1, 11'd1025, 24'd0,        10'd1023, 1'b1, 6'd18},
        '{1'b1, 11'd19,   24'd0,        10'd0,    1'b1, 6'd38},
        '{1'b0, 11'd0,    24'd7,        10'd5,    1'b0, 6'd0},
        '{1'b1, 11'd2,    24'd3,        10'd1,    1'b0, 6'd0},
        '{1'b1, 11'd420,  24'd840,      10'd0,    1'b1, 6'd19}
    };

    logic         clk;
    logic         rst_n;
    logic         cfg_wen;
    count_t       cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;

    count_t       ring_count;
    grad_t        grad_expected [$];
    logic         idle_on;
    int           mismatches;
    int           beats_sent;
    int           beats_checked;
    int           lit_beats;
    int           count_writes;

    led_chaser_intensity #(
        .HEAD_COUNT (HEAD_COUNT),
        .MAX_LEDS   (MAX_LEDS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic int unsigned ring_size(count_t count_reg);
        int unsigned m;
        m = count_reg;
        if (m == 0)
            m = 1;
        if (m > MAX_LEDS)
            m = MAX_LEDS;
        return m;
    endfunction

    function automatic grad_t chase_gradient(count_t count_reg, frame_t frame, led_t led);
        int unsigned m;
        int unsigned heads;
        int unsigned phase;
        int unsigned half;
        int unsigned pos;
        int unsigned distance;
        int unsigned best_d;
        int unsigned best_i;
        m = ring_size(count_reg);
        heads = (HEAD_COUNT < TABLE_HEADS) ? HEAD_COUNT : TABLE_HEADS;
        if (led >= m)
            return '0;
        phase = frame % m;
        half = phase >> 1;
        best_d = m;
        best_i = 0;
        for (int unsigned i = 0; i < heads; i++)
        begin
            pos = (HEAD_START[i] % m + phase) % m;
            if (i < FAST_HEADS)
                pos = (pos + half) % m;
            distance = (pos + m - led) % m;
            if (distance < best_d)
            begin
                best_d = distance;
                best_i = i;
            end
        end
        if (best_d >= NEAR_SPAN)
            return '0;
        if (best_i < FAST_HEADS)
            return grad_t'(FAST_PEAK - best_d);
        return grad_t'(SLOW_PEAK - best_d);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("led_chaser_intensity regression: fail");
        $finish;
    end

    // Result side: ready drops in random bursts while idling is enabled.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        grad_t seen;
        grad_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = m_axis_tdata[GRAD_W-1:0];
            if (grad_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected output beat: gradient_index %0d", seen);
            end
            else
            begin
                want = grad_expected.pop_front();
                beats_checked++;
                if (seen != 0)
                    lit_beats++;
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("gradient_index mismatch on beat %0d: expected %0d, got %0d",
                                 beats_checked, want, seen);
                end
            end
        end
    end

    task automatic wait_drained();
        while (grad_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_ring_count(count_t value);
        wait_drained();
        cfg_wen <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        ring_count = value;
        count_writes++;
    endtask

    task automatic send_led(frame_t frame, led_t led, logic known, grad_t value);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, led, frame};
        do
            @(posedge clk);
        while (!s_axis_tready);
        grad_expected.push_back(known ? value : chase_gradient(ring_count, frame, led));
        beats_sent++;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    initial
    begin
        count_t      value;
        frame_t      frame;
        led_t        led;
        int unsigned m;
        int          guard;
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        ring_count = count_t'(RESET_COUNT);
        idle_on = 1'b1;
        mismatches = 0;
        beats_sent = 0;
        beats_checked = 0;
        lit_beats = 0;
        count_writes = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < ROWS; r++)
        begin
            if (directed_rows[r].set_count)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                set_ring_count(directed_rows[r].count);
            end
            send_led(directed_rows[r].frame, directed_rows[r].led,
                     directed_rows[r].known, directed_rows[r].value);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: value = 11'd2047;
                1: value = 11'd1024;
                2: value = 11'd0;
                3: value = 11'd1;
                4: value = 11'd19;
                5: value = count_t'($urandom_range(2, 64));
                6: value = count_t'($urandom_range(65, 1023));
                7: value = count_t'($urandom_range(1025, 2047));
                default: value = count_t'(RESET_COUNT);
            endcase
            set_ring_count(value);
            idle_on = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            m = ring_size(ring_count);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                // Hold the sender off once until the pipeline has emptied.
                if (p == 4 && n == PHASE_BEATS / 2)
                begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge clk);
                    wait_drained();
                end
                case ($urandom_range(0, 4))
                    0: frame = frame_t'($urandom_range(0, 2 * m));
                    1: frame = frame_t'(24'hFFFFFF - $urandom_range(0, 2 * m));
                    default: frame = frame_t'($urandom);
                endcase
                if ($urandom_range(0, 6) == 0)
                    led = led_t'($urandom_range(0, 1023));
                else
                    led = led_t'($urandom_range(0, m - 1));
                send_led(frame, led, 1'b0, '0);
            end
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end

        idle_on = 1'b0;
        guard = 0;
        while (grad_expected.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
        if (grad_expected.size() != 0)
        begin
            mismatches++;
            $display("%0d expected beats never arrived", grad_expected.size());
        end

        $display("Sent %0d beats under %0d ring count writes; %0d output beats checked, %0d lit.",
                 beats_sent, count_writes, beats_checked, lit_beats);
        if (mismatches == 0)
            $display("led_chaser_intensity regression: pass");
        else
            $display("led_chaser_intensity regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
src/lci_pkg.sv
src/lci_mod_cell.sv
src/lci_mod_chain.sv
src/lci_nearest.sv
src/led_chaser_intensity.sv
dv/led_chaser_intensity_tb.sv
